// File: hdl/dndc_pkg.sv
// Package for the day number / Gregorian date converter.
// Holds field widths, calendar constants, reciprocal constants and month tables.
// No dependencies.
`timescale 1ns / 1ps

package dndc_pkg;

  localparam int YEAR_W     = 14;
  localparam int MONTH_W    = 4;
  localparam int DAY_W      = 5;
  localparam int DN_W       = 22;
  localparam int WD_W       = 3;
  localparam int S_TDATA_W  = 48;
  localparam int M_TDATA_W  = 56;
  localparam int PIPE_DEPTH = 12;

  localparam logic CMD_TO_NUMBER = 1'b0;
  localparam logic CMD_TO_DATE   = 1'b1;

  localparam logic [YEAR_W-1:0]  MAX_YEAR       = 14'd9999;
  localparam logic [MONTH_W-1:0] MONTHS         = 4'd12;
  localparam logic [DN_W-1:0]    MAX_DAY_NUMBER = 22'd3652059;
  localparam logic [DAY_W-1:0]   LAST_DEC_DAY   = 5'd31;

  localparam logic [YEAR_W-1:0] YEARS_CYCLE   = 14'd400;
  localparam logic [YEAR_W-1:0] YEARS_CENTURY = 14'd100;

  localparam logic [17:0] DAYS_400Y = 18'd146097;
  localparam logic [15:0] DAYS_100Y = 16'd36524;
  localparam logic [10:0] DAYS_4Y   = 11'd1461;
  localparam logic [8:0]  DAYS_1Y   = 9'd365;

  // Exact quotient by 100 for any 14-bit value after a right shift by 19.
  localparam logic [12:0] RECIP_100   = 13'd5243;
  // Floor reciprocals; the estimate is the quotient or one less.
  localparam logic [14:0] RECIP_400Y  = 15'd29398;
  localparam logic [15:0] RECIP_4Y    = 16'd45933;

  localparam logic [WD_W-1:0]  WD_FRIDAY     = 3'd5;
  localparam logic [WD_W-1:0]  WD_MOD        = 3'd7;
  localparam logic [DAY_W-1:0] UNLUCKY_DAY   = 5'd14;

  // First day of a month in a common year, zero-based month index.
  function automatic logic [8:0] month_start(input logic [MONTH_W-1:0] m);
    logic [8:0] r;
    unique case (m)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd59;
      4'd3:    r = 9'd90;
      4'd4:    r = 9'd120;
      4'd5:    r = 9'd151;
      4'd6:    r = 9'd181;
      4'd7:    r = 9'd212;
      4'd8:    r = 9'd243;
      4'd9:    r = 9'd273;
      4'd10:   r = 9'd304;
      4'd11:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // Length of a month in a common year, zero-based month index.
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] r;
    unique case (m)
      4'd1:                           r = 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:        r = 5'd30;
      4'd0, 4'd2, 4'd4, 4'd6, 4'd7,
      4'd9, 4'd11:                    r = 5'd31;
      default:                        r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

// File: hdl/day_number_date_converter_core.sv
// Top level of the day number / Gregorian date converter: a twelve-stage pipeline.
// Depends on dndc_pkg.
`timescale 1ns / 1ps

// Usage:
// One input transaction carries a command on s_axis_tuser and the operands on
// s_axis_tdata. Command 0 turns year, month and day into a day number with
// 0001-01-01 as day 1; command 1 turns a day number into year, month and day.
// Every input transaction yields exactly one output transaction with the day
// number, the date, the weekday (0 is Sunday), a Friday-the-14th flag on
// m_axis_tdata and the invalid flag on m_axis_tuser. An invalid input gives
// zeros in all data fields.
// Throughput is one transaction per cycle while the receiver does not stall;
// the depth is set by the chains of reciprocal multiply and correction for
// the 400-year and 4-year cycles.
// Each stage carries a valid bit and holds only while it is full and the stage
// after it holds, so empty stages keep taking input while the output waits.
// A stalled receiver never loses or repeats a transaction.
// Reset empties the pipeline; no output transaction is left pending.
module day_number_date_converter_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // in_year, in_month, in_day, in_day_number, zero fill
  input  logic [dndc_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  // command
  input  logic [0:0]                        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // out_day_number, out_year, out_month, out_day, weekday, friday_fourteenth, zero fill
  output logic [dndc_pkg::M_TDATA_W-1:0]    m_axis_tdata,
  // invalid
  output logic [0:0]                        m_axis_tuser
);

  import dndc_pkg::*;

  typedef struct packed {
    logic              cmd;
    logic [YEAR_W-1:0] year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]  day;
    logic [DN_W-1:0]   dn;
    logic [DN_W-1:0]   d0;
    logic              bad_dn;
    logic [26:0]       prod_y;
    logic [36:0]       prod_d0;
  } st1_t;

  typedef struct packed {
    logic              cmd;
    logic [YEAR_W-1:0] year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]  day;
    logic [DN_W-1:0]   dn;
    logic              bad_dn;
    logic [7:0]        q100;
    logic              y100z;
    logic [4:0]        q400e;
    logic [18:0]       r400;
  } st2_t;

  typedef struct packed {
    logic              cmd;
    logic              bad;
    logic [YEAR_W-1:0] year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]  day;
    logic [DN_W-1:0]   dn;
    logic [DN_W-1:0]   p365;
    logic [11:0]       p_quarter;
    logic [7:0]        q100p;
    logic [8:0]        fom;
    logic [4:0]        n400;
    logic [17:0]       d1;
  } st3_t;

  typedef struct packed {
    logic              cmd;
    logic              bad;
    logic [YEAR_W-1:0] year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]  day;
    logic [DN_W-1:0]   dn;
    logic [DN_W-1:0]   sum_a;
    logic [9:0]        sum_b;
    logic [4:0]        n400;
    logic [2:0]        n100;
    logic [15:0]       d2;
  } st4_t;

  typedef struct packed {
    logic              cmd;
    logic              bad;
    logic [YEAR_W-1:0] year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]  day;
    logic [DN_W-1:0]   num;
    logic [4:0]        n400;
    logic [2:0]        n100;
    logic [15:0]       d2;
    logic [31:0]       prod4;
  } st5_t;

  typedef struct packed {
    logic              cmd;
    logic              bad;
    logic [YEAR_W-1:0] year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]  day;
    logic [DN_W-1:0]   num;
    logic [4:0]        n400;
    logic [2:0]        n100;
    logic [5:0]        q4e;
    logic [11:0]       r4;
  } st6_t;

  typedef struct packed {
    logic              cmd;
    logic              bad;
    logic [YEAR_W-1:0] year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]  day;
    logic [DN_W-1:0]   num;
    logic [4:0]        n400;
    logic [2:0]        n100;
    logic [5:0]        n4;
    logic [10:0]       d3;
  } st7_t;

  typedef struct packed {
    logic              cmd;
    logic              bad;
    logic [YEAR_W-1:0] year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]  day;
    logic [DN_W-1:0]   num;
    logic [YEAR_W-1:0] year_c;
    logic [8:0]        doy;
    logic              last;
    logic              leap;
  } st8_t;

  typedef struct packed {
    logic              cmd;
    logic              bad;
    logic [YEAR_W-1:0] year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]  day;
    logic [DN_W-1:0]   num;
    logic [YEAR_W-1:0] year1;
    logic [11:1]       ge;
    logic [8:0]        doy;
    logic              last;
    logic              leap;
  } st9_t;

  typedef struct packed {
    logic              bad;
    logic [YEAR_W-1:0] year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]  day;
    logic [DN_W-1:0]   num;
  } st10_t;

  typedef struct packed {
    logic              bad;
    logic [YEAR_W-1:0] year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]  day;
    logic [DN_W-1:0]   num;
    logic [5:0]        dsum;
  } st11_t;

  typedef struct packed {
    logic              bad;
    logic              fri;
    logic [WD_W-1:0]   wd;
    logic [YEAR_W-1:0] year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]  day;
    logic [DN_W-1:0]   num;
  } st12_t;

  logic [PIPE_DEPTH-1:0] vld;
  logic [PIPE_DEPTH-1:0] adv;

  st1_t  st1,  st1_next;
  st2_t  st2,  st2_next;
  st3_t  st3,  st3_next;
  st4_t  st4,  st4_next;
  st5_t  st5,  st5_next;
  st6_t  st6,  st6_next;
  st7_t  st7,  st7_next;
  st8_t  st8,  st8_next;
  st9_t  st9,  st9_next;
  st10_t st10, st10_next;
  st11_t st11, st11_next;
  st12_t st12, st12_next;

  // A stage loads when it is empty or the stage after it loads.
  always_comb begin
    adv[PIPE_DEPTH-1] = !vld[PIPE_DEPTH-1] || m_axis_tready;
    for (int i = PIPE_DEPTH - 2; i >= 0; i--) begin
      adv[i] = !vld[i] || adv[i+1];
    end
  end

  assign s_axis_tready = adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= s_axis_tvalid;
      end
      for (int i = 1; i < PIPE_DEPTH; i++) begin
        if (adv[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0])  st1  <= st1_next;
    if (adv[1])  st2  <= st2_next;
    if (adv[2])  st3  <= st3_next;
    if (adv[3])  st4  <= st4_next;
    if (adv[4])  st5  <= st5_next;
    if (adv[5])  st6  <= st6_next;
    if (adv[6])  st7  <= st7_next;
    if (adv[7])  st8  <= st8_next;
    if (adv[8])  st9  <= st9_next;
    if (adv[9])  st10 <= st10_next;
    if (adv[10]) st11 <= st11_next;
    if (adv[11]) st12 <= st12_next;
  end

  // Stage 1: unpack, range check of the day number, reciprocal products.
  always_comb begin
    st1_next.cmd     = s_axis_tuser[0];
    st1_next.year    = s_axis_tdata[13:0];
    st1_next.month   = s_axis_tdata[17:14];
    st1_next.day     = s_axis_tdata[22:18];
    st1_next.dn      = s_axis_tdata[44:23];
    st1_next.d0      = st1_next.dn - 22'd1;
    st1_next.bad_dn  = (st1_next.dn == '0) || (st1_next.dn > MAX_DAY_NUMBER);
    st1_next.prod_y  = 27'(st1_next.year) * 27'(RECIP_100);
    st1_next.prod_d0 = 37'(st1_next.d0) * 37'(RECIP_400Y);
  end

  // Stage 2: century quotient of the year, first remainder of the day count.
  always_comb begin
    st2_next.cmd    = st1.cmd;
    st2_next.year   = st1.year;
    st2_next.month  = st1.month;
    st2_next.day    = st1.day;
    st2_next.dn     = st1.dn;
    st2_next.bad_dn = st1.bad_dn;
    st2_next.q100   = st1.prod_y[26:19];
    st2_next.y100z  = (st1.year == 14'({6'd0, st1.prod_y[26:19]} * YEARS_CENTURY));
    st2_next.q400e  = st1.prod_d0[36:32];
    st2_next.r400   = 19'(st1.d0 - 22'({17'd0, st1.prod_d0[36:32]} * 22'(DAYS_400Y)));
  end

  // Stage 3: leap year, date check, year terms; 400-year quotient correction.
  always_comb begin
    logic              leap;
    logic [MONTH_W-1:0] mi;
    logic [DAY_W-1:0]  mlen;
    logic              bad0;
    logic [YEAR_W-1:0] p;
    leap = (st2.year[1:0] == 2'd0) && (!st2.y100z || (st2.q100[1:0] == 2'd0));
    mi   = st2.month - 4'd1;
    mlen = month_len(mi) + 5'((mi == 4'd1) && leap);
    bad0 = (st2.year == '0) || (st2.year > MAX_YEAR) || (st2.month == '0) ||
           (st2.month > MONTHS) || (st2.day == '0) || (st2.day > mlen);
    p    = st2.year - 14'd1;
    st3_next.cmd       = st2.cmd;
    st3_next.bad       = (st2.cmd == CMD_TO_DATE) ? st2.bad_dn : bad0;
    st3_next.year      = st2.year;
    st3_next.month     = st2.month;
    st3_next.day       = st2.day;
    st3_next.dn        = st2.dn;
    st3_next.p365      = 22'({8'd0, p} * 22'(DAYS_1Y));
    st3_next.p_quarter = p[13:2];
    st3_next.q100p     = st2.q100 - 8'(st2.y100z);
    st3_next.fom       = month_start(mi) + 9'((mi >= 4'd2) && leap);
    if (st2.r400 >= 19'(DAYS_400Y)) begin
      st3_next.n400 = st2.q400e + 5'd1;
      st3_next.d1   = 18'(st2.r400 - 19'(DAYS_400Y));
    end else begin
      st3_next.n400 = st2.q400e;
      st3_next.d1   = st2.r400[17:0];
    end
  end

  // Stage 4: partial sums of the day number; century within the 400-year cycle.
  always_comb begin
    logic [2:0] n100;
    n100 = 3'(st3.d1 >= 18'(DAYS_100Y)) + 3'(st3.d1 >= 18'(2 * DAYS_100Y)) +
           3'(st3.d1 >= 18'(3 * DAYS_100Y)) + 3'(st3.d1 >= 18'(4 * DAYS_100Y));
    st4_next.cmd   = st3.cmd;
    st4_next.bad   = st3.bad;
    st4_next.year  = st3.year;
    st4_next.month = st3.month;
    st4_next.day   = st3.day;
    st4_next.dn    = st3.dn;
    st4_next.sum_a = st3.p365 + 22'(st3.p_quarter) - 22'(st3.q100p);
    st4_next.sum_b = 10'(st3.q100p[7:2]) + 10'(st3.fom) + 10'(st3.day);
    st4_next.n400  = st3.n400;
    st4_next.n100  = n100;
    st4_next.d2    = 16'(st3.d1 - 18'({15'd0, n100} * 18'(DAYS_100Y)));
  end

  // Stage 5: final day number for dates; 4-year reciprocal product.
  always_comb begin
    st5_next.cmd   = st4.cmd;
    st5_next.bad   = st4.bad;
    st5_next.year  = st4.year;
    st5_next.month = st4.month;
    st5_next.day   = st4.day;
    st5_next.num   = (st4.cmd == CMD_TO_DATE) ? st4.dn : (st4.sum_a + 22'(st4.sum_b));
    st5_next.n400  = st4.n400;
    st5_next.n100  = st4.n100;
    st5_next.d2    = st4.d2;
    st5_next.prod4 = 32'(st4.d2) * 32'(RECIP_4Y);
  end

  // Stage 6: 4-year quotient estimate and remainder.
  always_comb begin
    st6_next.cmd   = st5.cmd;
    st6_next.bad   = st5.bad;
    st6_next.year  = st5.year;
    st6_next.month = st5.month;
    st6_next.day   = st5.day;
    st6_next.num   = st5.num;
    st6_next.n400  = st5.n400;
    st6_next.n100  = st5.n100;
    st6_next.q4e   = st5.prod4[31:26];
    st6_next.r4    = 12'(st5.d2 - 16'({10'd0, st5.prod4[31:26]} * 16'(DAYS_4Y)));
  end

  // Stage 7: 4-year quotient correction.
  always_comb begin
    st7_next.cmd   = st6.cmd;
    st7_next.bad   = st6.bad;
    st7_next.year  = st6.year;
    st7_next.month = st6.month;
    st7_next.day   = st6.day;
    st7_next.num   = st6.num;
    st7_next.n400  = st6.n400;
    st7_next.n100  = st6.n100;
    if (st6.r4 >= 12'(DAYS_4Y)) begin
      st7_next.n4 = st6.q4e + 6'd1;
      st7_next.d3 = 11'(st6.r4 - 12'(DAYS_4Y));
    end else begin
      st7_next.n4 = st6.q4e;
      st7_next.d3 = st6.r4[10:0];
    end
  end

  // Stage 8: year within the 4-year cycle, day of year, leap of the target year.
  always_comb begin
    logic [2:0] n1;
    n1 = 3'(st7.d3 >= 11'(DAYS_1Y)) + 3'(st7.d3 >= 11'(2 * DAYS_1Y)) +
         3'(st7.d3 >= 11'(3 * DAYS_1Y)) + 3'(st7.d3 >= 11'(4 * DAYS_1Y));
    st8_next.cmd    = st7.cmd;
    st8_next.bad    = st7.bad;
    st8_next.year   = st7.year;
    st8_next.month  = st7.month;
    st8_next.day    = st7.day;
    st8_next.num    = st7.num;
    st8_next.year_c = 14'({9'd0, st7.n400} * YEARS_CYCLE) +
                      14'({11'd0, st7.n100} * YEARS_CENTURY) +
                      14'({8'd0, st7.n4} << 2) + 14'(n1);
    st8_next.doy    = 9'(st7.d3 - 11'({8'd0, n1} * 11'(DAYS_1Y)));
    st8_next.last   = (st7.n100 == 3'd4) || (n1 == 3'd4);
    st8_next.leap   = (n1 == 3'd3) && ((st7.n4 != 6'd24) || (st7.n100 == 3'd3));
  end

  // Stage 9: calendar year and month-start compares.
  always_comb begin
    st9_next.cmd   = st8.cmd;
    st9_next.bad   = st8.bad;
    st9_next.year  = st8.year;
    st9_next.month = st8.month;
    st9_next.day   = st8.day;
    st9_next.num   = st8.num;
    st9_next.year1 = st8.last ? st8.year_c : (st8.year_c + 14'd1);
    st9_next.doy   = st8.doy;
    st9_next.last  = st8.last;
    st9_next.leap  = st8.leap;
    for (int m = 1; m < 12; m++) begin
      st9_next.ge[m] = st8.doy >= (month_start(4'(m)) + 9'((m >= 2) && st8.leap));
    end
  end

  // Stage 10: month and day of month, merge of both commands.
  always_comb begin
    logic [MONTH_W-1:0] mi;
    logic [DAY_W-1:0]   dday;
    mi = '0;
    for (int m = 1; m < 12; m++) begin
      if (st9.ge[m]) begin
        mi = 4'(m);
      end
    end
    dday = 5'(st9.doy - (month_start(mi) + 9'((mi >= 4'd2) && st9.leap)) + 9'd1);
    st10_next.bad = st9.bad;
    st10_next.num = st9.num;
    if (st9.cmd == CMD_TO_DATE) begin
      st10_next.year = st9.year1;
      if (st9.last) begin
        st10_next.month = MONTHS;
        st10_next.day   = LAST_DEC_DAY;
      end else begin
        st10_next.month = mi + 4'd1;
        st10_next.day   = dday;
      end
    end else begin
      st10_next.year  = st9.year;
      st10_next.month = st9.month;
      st10_next.day   = st9.day;
    end
  end

  // Stage 11: octal digit sum of the day number, congruent to it modulo 7.
  always_comb begin
    logic [23:0] padded;
    padded = {2'b00, st10.num};
    st11_next.bad   = st10.bad;
    st11_next.year  = st10.year;
    st11_next.month = st10.month;
    st11_next.day   = st10.day;
    st11_next.num   = st10.num;
    st11_next.dsum  = '0;
    for (int k = 0; k < 8; k++) begin
      st11_next.dsum = st11_next.dsum + 6'(padded[3*k +: 3]);
    end
  end

  // Stage 12: weekday, flags and zeroing of invalid results.
  always_comb begin
    logic [3:0]      t;
    logic [WD_W-1:0] wd;
    t  = 4'(st11.dsum[5:3]) + 4'(st11.dsum[2:0]);
    wd = (t >= 4'(WD_MOD)) ? 3'(t - 4'(WD_MOD)) : t[2:0];
    st12_next.bad = st11.bad;
    if (st11.bad) begin
      st12_next.fri   = 1'b0;
      st12_next.wd    = '0;
      st12_next.year  = '0;
      st12_next.month = '0;
      st12_next.day   = '0;
      st12_next.num   = '0;
    end else begin
      st12_next.fri   = (wd == WD_FRIDAY) && (st11.day == UNLUCKY_DAY);
      st12_next.wd    = wd;
      st12_next.year  = st11.year;
      st12_next.month = st11.month;
      st12_next.day   = st11.day;
      st12_next.num   = st11.num;
    end
  end

  assign m_axis_tvalid = vld[PIPE_DEPTH-1];
  assign m_axis_tdata  = {7'd0, st12.fri, st12.wd, st12.day, st12.month, st12.year,
                          st12.num};
  assign m_axis_tuser  = st12.bad;

endmodule
